/* hdl/soqls_pkg.sv */
// shared types, codes and defaults for the sorted or queue list store
package soqls_pkg;

  localparam int CAPACITY_DEF    = 64;
  localparam int HANDLE_BITS_DEF = 16;
  localparam int KEY_W           = 32;

  localparam logic [2:0] FUNC_ADD        = 3'd0;
  localparam logic [2:0] FUNC_REM_FIRST  = 3'd1;
  localparam logic [2:0] FUNC_REM_KEY    = 3'd2;
  localparam logic [2:0] FUNC_REM_POS    = 3'd3;
  localparam logic [2:0] FUNC_TEST_KEY   = 3'd4;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_NOT_ALLOW = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;

  localparam logic [1:0] MODE_STACK  = 2'd0;
  localparam logic [1:0] MODE_QUEUE  = 2'd1;
  localparam logic [1:0] MODE_SORTED = 2'd2;

  localparam logic [1:0] ACT_HOLD   = 2'd0;
  localparam logic [1:0] ACT_INSERT = 2'd1;
  localparam logic [1:0] ACT_REMOVE = 2'd2;

  typedef struct packed {
    logic [1:0]              action;
    logic                    use_chain;
    logic signed [KEY_W-1:0] key;
  } cell_ctrl_t;

endpackage

/* hdl/soqls_cell.sv */
// one list cell: holds one entry, searches and shifts with its neighbors
module soqls_cell #(
  parameter int INDEX       = 0,
  parameter int HANDLE_BITS = soqls_pkg::HANDLE_BITS_DEF,
  parameter int IDX_W       = 7
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  soqls_pkg::cell_ctrl_t             ctrl,
  input  logic [IDX_W-1:0]                  idx,
  input  logic [HANDLE_BITS-1:0]            new_handle,
  input  logic signed [soqls_pkg::KEY_W-1:0] left_key,
  input  logic [HANDLE_BITS-1:0]            left_handle,
  input  logic                              left_valid,
  input  logic signed [soqls_pkg::KEY_W-1:0] right_key,
  input  logic [HANDLE_BITS-1:0]            right_handle,
  input  logic                              right_valid,
  input  logic                              before_prev,
  input  logic                              found_in,
  input  logic [HANDLE_BITS-1:0]            hout_in,
  output logic signed [soqls_pkg::KEY_W-1:0] key_o,
  output logic [HANDLE_BITS-1:0]            handle_o,
  output logic                              valid_o,
  output logic                              before_o,
  output logic                              found_o,
  output logic [HANDLE_BITS-1:0]            hout_o
);

  logic signed [soqls_pkg::KEY_W-1:0] key_r, key_nxt;
  logic [HANDLE_BITS-1:0]             handle_r, handle_nxt;
  logic                               valid_r, valid_nxt;
  logic                               lt;
  logic                               at_p;

  assign lt       = valid_r && (key_r < ctrl.key);
  assign before_o = ctrl.use_chain ? (before_prev & lt) : (IDX_W'(INDEX) < idx);
  assign at_p     = before_prev & ~before_o;
  assign found_o  = found_in | (at_p & valid_r & (key_r == ctrl.key));
  assign hout_o   = hout_in | (at_p ? handle_r : '0);

  assign key_o    = key_r;
  assign handle_o = handle_r;
  assign valid_o  = valid_r;

  always_comb begin
    key_nxt    = key_r;
    handle_nxt = handle_r;
    valid_nxt  = valid_r;
    case (ctrl.action)
      soqls_pkg::ACT_INSERT: begin
        if (at_p) begin
          key_nxt    = ctrl.key;
          handle_nxt = new_handle;
          valid_nxt  = 1'b1;
        end else if (!before_o) begin
          key_nxt    = left_key;
          handle_nxt = left_handle;
          valid_nxt  = left_valid;
        end
      end
      soqls_pkg::ACT_REMOVE: begin
        if (!before_o) begin
          key_nxt    = right_key;
          handle_nxt = right_handle;
          valid_nxt  = right_valid;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    key_r    <= key_nxt;
    handle_r <= handle_nxt;
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

endmodule

/* hdl/sorted_or_queue_list_store.sv */
// top level of the sorted or queue list store: decode, cell row and result register
// the result is registered and valid in the cycle after its input transfer
// one item per cycle unless out_ready stalls; the cell row searches and shifts combinationally
// an input transfer is taken while the result register is empty or being drained
// reset (rst_n low, synchronous) empties the store and sets stack mode; entry data keeps no reset
module sorted_or_queue_list_store #(
  parameter int CAPACITY    = soqls_pkg::CAPACITY_DEF,
  parameter int HANDLE_BITS = soqls_pkg::HANDLE_BITS_DEF,
  localparam int CW         = $clog2(CAPACITY + 1)
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [1:0]                         cfg_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [2:0]                         in_func,
  input  logic signed [soqls_pkg::KEY_W-1:0] in_key,
  input  logic [HANDLE_BITS-1:0]             in_handle,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [1:0]                         out_status,
  output logic [HANDLE_BITS-1:0]             out_handle_out,
  output logic [CW-1:0]                      out_entry_count
);

  logic [1:0]             mode_r;
  logic [CW-1:0]          count_r, count_nxt;
  logic                   out_valid_r;
  logic [1:0]             status_r, status_nxt;
  logic [HANDLE_BITS-1:0] hout_r, hout_nxt;
  logic                   acc;
  logic                   sorted;
  logic                   full;
  logic                   pos_ok;
  logic [CW-1:0]          idx;
  soqls_pkg::cell_ctrl_t  ctrl;

  logic signed [soqls_pkg::KEY_W-1:0] key_a    [CAPACITY+2];
  logic [HANDLE_BITS-1:0]             handle_a [CAPACITY+2];
  logic                               valid_a  [CAPACITY+2];
  logic                               before_c [CAPACITY+1];
  logic                               found_c  [CAPACITY+1];
  logic [HANDLE_BITS-1:0]             hout_c   [CAPACITY+1];

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid_r || out_ready;
  assign acc       = in_valid && in_ready;
  assign sorted    = mode_r[1];
  assign full      = (count_r == CW'(CAPACITY));
  assign pos_ok    = !in_key[soqls_pkg::KEY_W-1] && (in_key != '0)
                     && (in_key <= $signed({{(soqls_pkg::KEY_W-CW){1'b0}}, count_r}));

  assign key_a[0]             = '0;
  assign handle_a[0]          = '0;
  assign valid_a[0]           = 1'b0;
  assign key_a[CAPACITY+1]    = '0;
  assign handle_a[CAPACITY+1] = '0;
  assign valid_a[CAPACITY+1]  = 1'b0;
  assign before_c[0]          = 1'b1;
  assign found_c[0]           = 1'b0;
  assign hout_c[0]            = '0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    soqls_cell #(
      .INDEX       (i),
      .HANDLE_BITS (HANDLE_BITS),
      .IDX_W       (CW)
    ) u_cell (
      .clk          (clk),
      .rst_n        (rst_n),
      .ctrl         (ctrl),
      .idx          (idx),
      .new_handle   (in_handle),
      .left_key     (key_a[i]),
      .left_handle  (handle_a[i]),
      .left_valid   (valid_a[i]),
      .right_key    (key_a[i+2]),
      .right_handle (handle_a[i+2]),
      .right_valid  (valid_a[i+2]),
      .before_prev  (before_c[i]),
      .found_in     (found_c[i]),
      .hout_in      (hout_c[i]),
      .key_o        (key_a[i+1]),
      .handle_o     (handle_a[i+1]),
      .valid_o      (valid_a[i+1]),
      .before_o     (before_c[i+1]),
      .found_o      (found_c[i+1]),
      .hout_o       (hout_c[i+1])
    );
  end

  always_comb begin
    ctrl.action    = soqls_pkg::ACT_HOLD;
    ctrl.use_chain = sorted;
    ctrl.key       = in_key;
    idx            = '0;
    status_nxt     = soqls_pkg::ST_NOT_ALLOW;
    hout_nxt       = '0;
    count_nxt      = count_r;
    case (in_func)
      soqls_pkg::FUNC_ADD: begin
        if (full) begin
          status_nxt = soqls_pkg::ST_FULL;
        end else begin
          status_nxt  = soqls_pkg::ST_OK;
          ctrl.action = soqls_pkg::ACT_INSERT;
          idx         = (mode_r == soqls_pkg::MODE_QUEUE) ? count_r : '0;
          count_nxt   = count_r + 1'b1;
        end
      end
      soqls_pkg::FUNC_REM_FIRST: begin
        if (!sorted) begin
          if (count_r == '0) begin
            status_nxt = soqls_pkg::ST_NOT_FOUND;
          end else begin
            status_nxt  = soqls_pkg::ST_OK;
            ctrl.action = soqls_pkg::ACT_REMOVE;
            hout_nxt    = hout_c[CAPACITY];
            count_nxt   = count_r - 1'b1;
          end
        end
      end
      soqls_pkg::FUNC_REM_KEY, soqls_pkg::FUNC_TEST_KEY: begin
        if (sorted) begin
          if (found_c[CAPACITY]) begin
            status_nxt = soqls_pkg::ST_OK;
            if (in_func == soqls_pkg::FUNC_REM_KEY) begin
              ctrl.action = soqls_pkg::ACT_REMOVE;
              hout_nxt    = hout_c[CAPACITY];
              count_nxt   = count_r - 1'b1;
            end
          end else begin
            status_nxt = soqls_pkg::ST_NOT_FOUND;
          end
        end
      end
      soqls_pkg::FUNC_REM_POS: begin
        ctrl.use_chain = 1'b0;
        idx            = in_key[CW-1:0] - 1'b1;
        if (sorted) begin
          if (pos_ok) begin
            status_nxt  = soqls_pkg::ST_OK;
            ctrl.action = soqls_pkg::ACT_REMOVE;
            hout_nxt    = hout_c[CAPACITY];
            count_nxt   = count_r - 1'b1;
          end else begin
            status_nxt = soqls_pkg::ST_NOT_FOUND;
          end
        end
      end
      default: begin
      end
    endcase
    if (!acc) begin
      ctrl.action = soqls_pkg::ACT_HOLD;
      count_nxt   = count_r;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      status_r <= status_nxt;
      hout_r   <= hout_nxt;
    end
    if (!rst_n) begin
      mode_r      <= soqls_pkg::MODE_STACK;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        mode_r <= cfg_data;
      end
      count_r <= count_nxt;
      if (acc) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = status_r;
  assign out_handle_out  = hout_r;
  assign out_entry_count = count_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_full_refused: assert property (@(posedge clk) disable iff (!rst_n)
    acc && (in_func == soqls_pkg::FUNC_ADD) && full
    |=> (out_status == soqls_pkg::ST_FULL) && $stable(count_r))
    else $error("add to full store not refused");

  a_refusal_no_handle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != soqls_pkg::ST_OK) |-> (out_handle_out == '0))
    else $error("handle returned on refused transfer");

  a_count_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !acc |=> $stable(count_r))
    else $error("entry count moved without input transfer");

endmodule

/* test/sorted_or_queue_list_store_checker.sv */
// list store checker: mirrors the held entries, predicts each reply and compares it
module sorted_or_queue_list_store_checker (
  input  logic                                          clk,
  input  logic                                          rst_n,
  input  logic                                          cfg_valid,
  input  logic                                          cfg_ready,
  input  logic [1:0]                                    cfg_data,
  input  logic                                          in_valid,
  input  logic                                          in_ready,
  input  logic [2:0]                                    in_func,
  input  logic signed [soqls_pkg::KEY_W-1:0]            in_key,
  input  logic [soqls_pkg::HANDLE_BITS_DEF-1:0]         in_handle,
  input  logic                                          out_valid,
  input  logic                                          out_ready,
  input  logic [1:0]                                    out_status,
  input  logic [soqls_pkg::HANDLE_BITS_DEF-1:0]         out_handle_out,
  input  logic [$clog2(soqls_pkg::CAPACITY_DEF + 1)-1:0] out_entry_count,
  output int                                            fail_count,
  output int                                            done_count,
  output int                                            open_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CW = $clog2(soqls_pkg::CAPACITY_DEF + 1);

  typedef struct packed {
    logic signed [soqls_pkg::KEY_W-1:0]      key;
    logic [soqls_pkg::HANDLE_BITS_DEF-1:0]   hnd;
  } list_entry_t;

  typedef struct packed {
    logic [1:0]                            status;
    logic [soqls_pkg::HANDLE_BITS_DEF-1:0] hnd;
    logic [CW-1:0]                         cnt;
  } reply_t;

  list_entry_t list_image[$];
  reply_t      replies_due[$];
  logic [1:0]  cur_mode;
  int          err_n;
  int          seen_n;

  initial begin
    fail_count = 0;
    done_count = 0;
    open_count = 0;
    err_n = 0;
    seen_n = 0;
    cur_mode = soqls_pkg::MODE_STACK;
  end

  function automatic int first_not_below(input logic signed [soqls_pkg::KEY_W-1:0] k);
    int i;
    i = 0;
    while (i < list_image.size() && $signed(list_image[i].key) < k) i++;
    return i;
  endfunction

  function automatic reply_t run_op(input logic [2:0] op,
                                    input logic signed [soqls_pkg::KEY_W-1:0] k,
                                    input logic [soqls_pkg::HANDLE_BITS_DEF-1:0] h);
    reply_t      r;
    list_entry_t e;
    int          p;
    logic        by_key;
    by_key = (cur_mode >= soqls_pkg::MODE_SORTED);
    r.status = soqls_pkg::ST_NOT_ALLOW;
    r.hnd = '0;
    e.key = k;
    e.hnd = h;
    case (op)
      soqls_pkg::FUNC_ADD: begin
        if (list_image.size() >= soqls_pkg::CAPACITY_DEF) begin
          r.status = soqls_pkg::ST_FULL;
        end else begin
          if (by_key) list_image.insert(first_not_below(k), e);
          else if (cur_mode == soqls_pkg::MODE_STACK) list_image.push_front(e);
          else list_image.push_back(e);
          r.status = soqls_pkg::ST_OK;
        end
      end
      soqls_pkg::FUNC_REM_FIRST: begin
        if (!by_key) begin
          if (list_image.size() == 0) begin
            r.status = soqls_pkg::ST_NOT_FOUND;
          end else begin
            e = list_image.pop_front();
            r.hnd = e.hnd;
            r.status = soqls_pkg::ST_OK;
          end
        end
      end
      soqls_pkg::FUNC_REM_KEY, soqls_pkg::FUNC_TEST_KEY: begin
        if (by_key) begin
          p = first_not_below(k);
          if (p < list_image.size() && $signed(list_image[p].key) == k) begin
            if (op == soqls_pkg::FUNC_REM_KEY) begin
              r.hnd = list_image[p].hnd;
              list_image.delete(p);
            end
            r.status = soqls_pkg::ST_OK;
          end else begin
            r.status = soqls_pkg::ST_NOT_FOUND;
          end
        end
      end
      soqls_pkg::FUNC_REM_POS: begin
        if (by_key) begin
          if (k >= 1 && k <= list_image.size()) begin
            p = int'(k) - 1;
            r.hnd = list_image[p].hnd;
            list_image.delete(p);
            r.status = soqls_pkg::ST_OK;
          end else begin
            r.status = soqls_pkg::ST_NOT_FOUND;
          end
        end
      end
      default: r.status = soqls_pkg::ST_NOT_ALLOW;
    endcase
    r.cnt = CW'(list_image.size());
    return r;
  endfunction

  always @(posedge clk) begin
    reply_t got;
    reply_t want;
    if (!rst_n) begin
      list_image.delete();
      replies_due.delete();
      cur_mode = soqls_pkg::MODE_STACK;
    end else begin
      // a reply leaving now belongs to an older transfer than one entering now
      if (out_valid && out_ready) begin
        got.status = out_status;
        got.hnd = out_handle_out;
        got.cnt = out_entry_count;
        seen_n++;
        if (replies_due.size() == 0) begin
          err_n++;
          $display("%0t: unexpected reply status %0d handle %h count %0d",
                   $time, got.status, got.hnd, got.cnt);
        end else begin
          want = replies_due.pop_front();
          if (got.status !== want.status) begin
            err_n++;
            $display("%0t: status expected %0d got %0d", $time, want.status, got.status);
          end
          if (got.hnd !== want.hnd) begin
            err_n++;
            $display("%0t: handle expected %h got %h", $time, want.hnd, got.hnd);
          end
          if (got.cnt !== want.cnt) begin
            err_n++;
            $display("%0t: count expected %0d got %0d", $time, want.cnt, got.cnt);
          end
        end
      end
      if (cfg_valid && cfg_ready) cur_mode = cfg_data;
      if (in_valid && in_ready) replies_due.push_back(run_op(in_func, in_key, in_handle));
    end
    fail_count <= err_n;
    done_count <= seen_n;
    open_count <= replies_due.size();
  end

endmodule

/* test/sorted_or_queue_list_store_tb.sv */
// testbench top for the list store: clock, reset, stimulus, stalls and verdict
module sorted_or_queue_list_store_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CW = $clog2(soqls_pkg::CAPACITY_DEF + 1);
  localparam int CYCLE_LIMIT = 400000;
  localparam logic [1:0] MODE_SORTED_ALT = 2'd3;
  localparam logic [2:0] FUNC_RSVD_FIRST = 3'd5;
  localparam logic [2:0] FUNC_RSVD_LAST  = 3'd7;

  logic                                   clk = 1'b0;
  logic                                   rst_n = 1'b0;
  logic                                   cfg_valid = 1'b0;
  logic                                   cfg_ready;
  logic [1:0]                             cfg_data = soqls_pkg::MODE_STACK;
  logic                                   in_valid = 1'b0;
  logic                                   in_ready;
  logic [2:0]                             in_func = soqls_pkg::FUNC_ADD;
  logic signed [soqls_pkg::KEY_W-1:0]     in_key = '0;
  logic [soqls_pkg::HANDLE_BITS_DEF-1:0]  in_handle = '0;
  logic                                   out_valid;
  logic                                   out_ready = 1'b0;
  logic [1:0]                             out_status;
  logic [soqls_pkg::HANDLE_BITS_DEF-1:0]  out_handle_out;
  logic [CW-1:0]                          out_entry_count;

  int fail_count;
  int done_count;
  int open_count;
  int sent_count = 0;
  int send_idle = 0;
  int recv_idle = 0;
  int hold_len = 0;
  int cycle_n = 0;

  sorted_or_queue_list_store dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_func         (in_func),
    .in_key          (in_key),
    .in_handle       (in_handle),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_handle_out  (out_handle_out),
    .out_entry_count (out_entry_count)
  );

  sorted_or_queue_list_store_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_func         (in_func),
    .in_key          (in_key),
    .in_handle       (in_handle),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_handle_out  (out_handle_out),
    .out_entry_count (out_entry_count),
    .fail_count      (fail_count),
    .done_count      (done_count),
    .open_count      (open_count)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  always @(posedge clk) begin
    cycle_n++;
    if (cycle_n >= CYCLE_LIMIT) begin
      $display("sorted_or_queue_list_store_tb NOT OK");
      $finish;
    end
  end

  // receiver: random stalls plus an occasional long hold-off
  initial begin
    forever begin
      @(posedge clk);
      if (hold_len > 0) begin
        out_ready <= 1'b0;
        repeat (hold_len) @(posedge clk);
        hold_len = 0;
      end
      out_ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  task automatic send_item(input logic [2:0] op, input logic signed [soqls_pkg::KEY_W-1:0] k,
                           input logic [soqls_pkg::HANDLE_BITS_DEF-1:0] h);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_func <= op;
    in_key <= k;
    in_handle <= h;
    do @(posedge clk); while (!in_ready);
    sent_count++;
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (done_count < sent_count);
  endtask

  task automatic set_mode(input logic [1:0] md);
    wait_drain();
    cfg_valid <= 1'b1;
    cfg_data <= md;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_item(input logic [1:0] md, input int add_pct);
    logic [2:0]                         op;
    logic signed [soqls_pkg::KEY_W-1:0] k;
    int                                 r;
    r = $urandom_range(99);
    if (r < 70) k = $urandom_range(16) - 8;
    else if (r < 90) k = $urandom;
    else begin
      case ($urandom_range(3))
        0: k = 32'h7fffffff;
        1: k = 32'h80000000;
        2: k = '1;
        default: k = '0;
      endcase
    end
    r = $urandom_range(99);
    if (r < add_pct) begin
      op = soqls_pkg::FUNC_ADD;
    end else if (md < soqls_pkg::MODE_SORTED) begin
      if ($urandom_range(99) < 85) op = soqls_pkg::FUNC_REM_FIRST;
      else op = 3'($urandom_range(FUNC_RSVD_LAST, soqls_pkg::FUNC_REM_KEY));
    end else begin
      r = $urandom_range(99);
      if (r < 35) begin
        op = soqls_pkg::FUNC_REM_KEY;
      end else if (r < 65) begin
        op = soqls_pkg::FUNC_REM_POS;
        if ($urandom_range(99) < 80) k = $urandom_range(66);
      end else if (r < 90) begin
        op = soqls_pkg::FUNC_TEST_KEY;
      end else if (r < 95) begin
        op = soqls_pkg::FUNC_REM_FIRST;
      end else begin
        op = 3'($urandom_range(FUNC_RSVD_LAST, FUNC_RSVD_FIRST));
      end
    end
    send_item(op, k, 16'($urandom));
  endtask

  initial begin
    int          phase;
    int          sub;
    int          n;
    int          add_pct[8];
    logic [1:0]  mode_seq[8];
    add_pct = '{85, 85, 30, 60, 85, 20, 50, 90};
    mode_seq = '{soqls_pkg::MODE_SORTED, soqls_pkg::MODE_STACK, soqls_pkg::MODE_QUEUE,
                 MODE_SORTED_ALT, soqls_pkg::MODE_SORTED, soqls_pkg::MODE_QUEUE,
                 soqls_pkg::MODE_SORTED, soqls_pkg::MODE_STACK};
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_idle = 25;
    recv_idle = 54;

    // stack mode after reset
    send_item(soqls_pkg::FUNC_REM_FIRST, '0, 16'hffff);
    send_item(soqls_pkg::FUNC_ADD, 32'h7fffffff, 16'hffff);
    send_item(soqls_pkg::FUNC_ADD, 32'h80000000, 16'h0000);
    send_item(soqls_pkg::FUNC_ADD, '0, 16'h1234);
    send_item(soqls_pkg::FUNC_TEST_KEY, '0, '0);
    send_item(soqls_pkg::FUNC_REM_KEY, '0, '0);
    send_item(soqls_pkg::FUNC_REM_POS, 32'sd1, '0);
    send_item(FUNC_RSVD_FIRST, '0, '0);
    send_item(FUNC_RSVD_LAST, '1, '1);
    send_item(soqls_pkg::FUNC_REM_FIRST, '0, '0);
    set_mode(soqls_pkg::MODE_QUEUE);
    send_item(soqls_pkg::FUNC_ADD, 32'sd5, 16'h0005);
    send_item(soqls_pkg::FUNC_REM_FIRST, '0, '0);
    // sorted mode with entries already held out of order
    set_mode(soqls_pkg::MODE_SORTED);
    send_item(soqls_pkg::FUNC_ADD, 32'sd5, 16'haaaa);
    send_item(soqls_pkg::FUNC_ADD, -32'sd3, 16'h5555);
    send_item(soqls_pkg::FUNC_TEST_KEY, 32'sd5, '0);
    send_item(soqls_pkg::FUNC_TEST_KEY, 32'sd6, '0);
    send_item(soqls_pkg::FUNC_REM_KEY, 32'sd5, '0);
    send_item(soqls_pkg::FUNC_REM_POS, '0, '0);
    send_item(soqls_pkg::FUNC_REM_POS, 32'h80000000, '0);
    send_item(soqls_pkg::FUNC_REM_POS, 32'h7fffffff, '0);
    send_item(soqls_pkg::FUNC_REM_POS, 32'sd1, '0);
    send_item(soqls_pkg::FUNC_REM_FIRST, '0, '0);
    set_mode(MODE_SORTED_ALT);
    send_item(soqls_pkg::FUNC_ADD, 32'sd2, 16'h00f0);
    send_item(soqls_pkg::FUNC_REM_POS, 32'sd2, '0);
    send_item(3'(FUNC_RSVD_FIRST + 1), '0, '0);

    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin send_idle = 25; recv_idle = 54; end
        1: begin send_idle = 54; recv_idle = 25; end
        default: begin send_idle = 0; recv_idle = 0; end
      endcase
      for (sub = 0; sub < 8; sub++) begin
        set_mode(mode_seq[sub]);
        if (sub == 3 && phase != 1) hold_len = 300;
        for (n = 0; n < 85; n++) random_item(mode_seq[sub], add_pct[sub]);
      end
    end

    wait_drain();
    repeat (8) @(posedge clk);
    if (fail_count == 0 && open_count == 0) begin
      $display("sorted_or_queue_list_store_tb OK");
    end else begin
      $display("sorted_or_queue_list_store_tb NOT OK");
    end
    $finish;
  end

endmodule
